// File: hw/rtl/polynomial_derivative_eval_macros.svh
// Assertion macros for the polynomial derivative evaluator.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef POLYNOMIAL_DERIVATIVE_EVAL_MACROS_SVH
`define POLYNOMIAL_DERIVATIVE_EVAL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pde assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PDE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pde assertion failed");

`endif

// File: hw/rtl/pde_pkg.sv
// Shared types, constants and the falling factorial table builder
// for the polynomial derivative evaluator. No dependencies.
package pde_pkg;

    localparam int POINT_W = 16;
    localparam int ORDER_W = 4;
    localparam int COEF_W  = 16;
    localparam int VALUE_W = 64;
    localparam int PROD_W  = VALUE_W + COEF_W;
    localparam int DEG_W   = 3;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;
    localparam int NUM_COEF_REGS = 7;
    localparam int FALL_N  = 1 << ORDER_W;

    // register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_DEGREE = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF0  = 3'd1;

    typedef struct packed {
        logic [POINT_W-1:0] x;
        logic [ORDER_W-1:0] d;
        logic [VALUE_W-1:0] acc;
        logic [VALUE_W-1:0] term;
    } pde_stage_t;

    // Falling factorials t*(t-1)*...*(t-d+1) for every order d, modulo 2^64.
    typedef logic [FALL_N-1:0][VALUE_W-1:0] fall_row_t;

    function automatic fall_row_t fall_row(input int t);
        fall_row_t row;
        logic [VALUE_W-1:0] f;
        for (int dd = 0; dd < FALL_N; dd++)
        begin
            f = 64'd1;
            for (int j = 0; j < FALL_N; j++)
            begin
                if (j < dd)
                begin
                    f = f * VALUE_W'(longint'(t) - longint'(j));
                end
            end
            row[dd] = f;
        end
        return row;
    endfunction

endpackage

// File: hw/rtl/pde_cell.sv
// One Horner cell: folds in the term of power TERM and prepares the scaled
// coefficient of the next lower power for its neighbor. Depends on pde_pkg.
module pde_cell
    import pde_pkg::*;
#(
    parameter int TERM = 0
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  pde_stage_t                up_data,
    input  logic [ORDER_W-1:0]        degree,
    input  logic signed [COEF_W-1:0]  coef_next,
    output logic                      down_valid,
    input  logic                      down_ready,
    output pde_stage_t                down_data
);

    localparam logic [ORDER_W:0] TERM_IDX = (ORDER_W+1)'(TERM);
    localparam int NEXT_TERM = (TERM > 0) ? TERM - 1 : 0;
    localparam fall_row_t FALL = fall_row(NEXT_TERM);

    logic              v_reg;
    logic              v_next;
    pde_stage_t        data_reg;
    pde_stage_t        data_next;
    logic signed [PROD_W-1:0] acc_prod;
    logic signed [PROD_W-1:0] term_prod;

    assign acc_prod  = $signed(up_data.acc) * $signed(up_data.x);
    assign term_prod = $signed(FALL[up_data.d]) * $signed(coef_next);

    always_comb
    begin
        data_next      = up_data;
        data_next.term = term_prod[VALUE_W-1:0];
        if ({1'b0, degree} < TERM_IDX)
        begin
            // power above the degree: nothing accumulated yet
            data_next.acc = '0;
        end
        else if ({1'b0, up_data.d} > TERM_IDX)
        begin
            // power below the order: hold the finished sum
            data_next.acc = up_data.acc;
        end
        else
        begin
            data_next.acc = acc_prod[VALUE_W-1:0] + up_data.term;
        end
    end

    assign up_ready = !v_reg || down_ready;
    assign v_next   = up_ready ? up_valid : v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = v_reg;
    assign down_data  = data_reg;

endmodule

// File: hw/rtl/pde_regs.sv
// Configuration register file: degree and coefficients behind an APB-style
// port. Depends on pde_pkg.
module pde_regs
    import pde_pkg::*;
#(
    parameter int MAX_DEGREE = 6
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic [ORDER_W-1:0]       degree,
    output logic signed [COEF_W-1:0] coef [MAX_DEGREE+1]
);

    localparam int NUM_COEF = (MAX_DEGREE < NUM_COEF_REGS) ? MAX_DEGREE + 1 : NUM_COEF_REGS;
    localparam logic [ORDER_W-1:0] MAX_DEG = ORDER_W'(MAX_DEGREE);

    logic [DEG_W-1:0]  poly_degree_reg;
    logic [COEF_W-1:0] coef_reg [NUM_COEF];
    logic [IDX_W-1:0]  idx;
    logic              wr_en;

    assign idx   = paddr[ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_degree_reg <= '0;
            for (int k = 0; k < NUM_COEF; k++)
            begin
                coef_reg[k] <= '0;
            end
        end
        else if (wr_en)
        begin
            if (idx == REG_DEGREE)
            begin
                poly_degree_reg <= pwdata[DEG_W-1:0];
            end
            for (int k = 0; k < NUM_COEF; k++)
            begin
                if (idx == REG_COEF0 + IDX_W'(k))
                begin
                    coef_reg[k] <= pwdata[COEF_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            REG_DEGREE:
            begin
                prdata = DATA_W'(poly_degree_reg);
            end
            default:
            begin
                for (int k = 0; k < NUM_COEF; k++)
                begin
                    if (idx == REG_COEF0 + IDX_W'(k))
                    begin
                        prdata = {{(DATA_W-COEF_W){coef_reg[k][COEF_W-1]}}, coef_reg[k]};
                    end
                end
            end
        endcase
    end

    // saturate the degree to MAX_DEGREE
    assign degree = ({1'b0, poly_degree_reg} > MAX_DEG) ? MAX_DEG : {1'b0, poly_degree_reg};

    always_comb
    begin
        for (int k = 0; k <= MAX_DEGREE; k++)
        begin
            coef[k] = '0;
        end
        for (int k = 0; k < NUM_COEF; k++)
        begin
            coef[k] = $signed(coef_reg[k]);
        end
    end

endmodule

// File: hw/rtl/polynomial_derivative_eval.sv
// Polynomial derivative evaluator top level: register file plus a chain of
// Horner cells. Depends on pde_pkg, pde_regs, pde_cell and the macros header.
//
// Each transfer on the item channel (point, deriv_order) yields one value on
// the result channel: the deriv_order-th derivative of the configured
// polynomial at point, wrapping modulo 2^64, zero when the order exceeds the
// degree. A row of MAX_DEGREE+2 Horner cells, one per power from MAX_DEGREE+1
// down to 0, moves each item one cell per cycle when not stalled, so a new
// item enters every cycle unless the result side stalls. Each cell registers
// the item; its 64x16 multiply-add sets the clock. Stalls on the result side
// back up only as far as the chain is full. The user must write degree and
// coefficients through the APB-style port only while no item is in flight;
// the block does not check it. A degree above MAX_DEGREE acts as MAX_DEGREE.
`include "polynomial_derivative_eval_macros.svh"

module polynomial_derivative_eval
    import pde_pkg::*;
#(
    parameter int MAX_DEGREE = 6
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  logic signed [POINT_W-1:0] point,
    input  logic [ORDER_W-1:0]        deriv_order,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic signed [VALUE_W-1:0] value
);

    localparam int NUM_CELLS = MAX_DEGREE + 2;
    localparam int CNT_W     = $clog2(NUM_CELLS + 1);

    logic [ORDER_W-1:0]        degree;
    logic signed [COEF_W-1:0]  coef [MAX_DEGREE+1];
    pde_stage_t                link_data  [NUM_CELLS+1];
    logic [NUM_CELLS:0]        link_valid;
    logic [NUM_CELLS:0]        link_ready;
    logic [NUM_CELLS-1:0]      cell_valid;
    logic [CNT_W-1:0]          cell_count;
    logic                      item_fire;
    logic                      result_fire;

    assign pready = 1'b1;

    pde_regs #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .degree  (degree),
        .coef    (coef)
    );

    always_comb
    begin
        link_data[0].x    = point;
        link_data[0].d    = deriv_order;
        link_data[0].acc  = '0;
        link_data[0].term = '0;
    end
    assign link_valid[0]         = item_valid;
    assign item_ready            = link_ready[0];
    assign link_ready[NUM_CELLS] = result_ready;

    for (genvar j = 0; j < NUM_CELLS; j++)
    begin : g_cell
        logic signed [COEF_W-1:0] coef_next;

        if (j < NUM_CELLS - 1)
        begin : g_coef
            assign coef_next = coef[NUM_CELLS - 2 - j];
        end
        else
        begin : g_last
            assign coef_next = '0;
        end

        pde_cell #(
            .TERM (NUM_CELLS - 1 - j)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (link_valid[j]),
            .up_ready   (link_ready[j]),
            .up_data    (link_data[j]),
            .degree     (degree),
            .coef_next  (coef_next),
            .down_valid (link_valid[j+1]),
            .down_ready (link_ready[j+1]),
            .down_data  (link_data[j+1])
        );

        assign cell_valid[j] = link_valid[j+1];
    end

    assign result_valid = link_valid[NUM_CELLS];
    assign value        = $signed(link_data[NUM_CELLS].acc);

    assign item_fire   = item_valid && item_ready;
    assign result_fire = result_valid && result_ready;
    assign cell_count  = CNT_W'($countones(cell_valid));

    `PDE_ASSERT_SAME(a_ready_when_drained, !result_valid, item_ready)
    `PDE_ASSERT_NEXT(a_count_up, item_fire && !result_fire, cell_count == $past(cell_count) + 1)
    `PDE_ASSERT_NEXT(a_count_down, result_fire && !item_fire, cell_count + 1 == $past(cell_count))

endmodule

// File: tb/tb.sv
// Self-checking testbench for polynomial_derivative_eval: drives points over the
// item channel, writes the polynomial through the APB-style port, and checks each value.
// Depends on pde_pkg and the polynomial_derivative_eval RTL.
module tb;
    import pde_pkg::*;

    localparam int MAX_DEG   = 6;
    localparam int LATENCY   = MAX_DEG + 2;
    localparam int CYCLE_CAP = 300000;

    typedef struct {
        logic signed [POINT_W-1:0] x;
        logic [ORDER_W-1:0]        d;
        logic [VALUE_W-1:0]        v;
    } deriv_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [DATA_W-1:0]         pwdata;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      item_valid;
    logic                      item_ready;
    logic signed [POINT_W-1:0] point;
    logic [ORDER_W-1:0]        deriv_order;
    logic                      result_valid;
    logic                      result_ready;
    logic signed [VALUE_W-1:0] value;

    // shadow copy of the polynomial as the block should hold it
    logic [DEG_W-1:0]         degree_shadow;
    logic signed [COEF_W-1:0] coef_shadow [MAX_DEG+1];

    deriv_result_t pending_values [$];
    deriv_result_t head_value;
    int            errors;
    int            cycles;
    bit            idle_on;
    int            stall_left;

    polynomial_derivative_eval #(
        .MAX_DEGREE(MAX_DEG)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .point       (point),
        .deriv_order (deriv_order),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .value       (value)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Horner over the scaled terms, top power down to the order, modulo 2^64
    function automatic logic [VALUE_W-1:0] eval_derivative(logic signed [POINT_W-1:0] x,
                                                           logic [ORDER_W-1:0] d);
        logic [VALUE_W-1:0] acc;
        logic [VALUE_W-1:0] fall;
        logic [VALUE_W-1:0] xw;
        int                 top;
        acc = '0;
        xw  = VALUE_W'(x);
        top = int'(degree_shadow);
        if (top > MAX_DEG)
        begin
            top = MAX_DEG;
        end
        if (int'(d) <= top)
        begin
            for (int t = top; t >= int'(d); t--)
            begin
                fall = 64'd1;
                for (int j = 0; j < int'(d); j++)
                begin
                    fall = fall * VALUE_W'(t - j);
                end
                acc = acc * xw + fall * VALUE_W'(coef_shadow[t]);
            end
        end
        return acc;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: stall in short random bursts while idling is on
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_ready = 1'b1;
            stall_left   = 0;
        end
        else if (stall_left > 0)
        begin
            result_ready = 1'b0;
            stall_left   = stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            result_ready = 1'b0;
            stall_left   = $urandom_range(0, 2);
        end
        else
        begin
            result_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_values.size() == 0)
            begin
                errors++;
                $error("value: no result expected, actual %0d", value);
            end
            else
            begin
                head_value = pending_values.pop_front();
                if (value !== head_value.v)
                begin
                    errors++;
                    $error("value (point %0d, order %0d): expected %0d, actual %0d",
                           head_value.x, head_value.d, $signed(head_value.v), value);
                end
            end
        end
    end

    task automatic send_point(logic signed [POINT_W-1:0] x, logic [ORDER_W-1:0] d);
        deriv_result_t r;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        item_valid  = 1'b1;
        point       = x;
        deriv_order = d;
        do
            @(posedge clk);
        while (!item_ready);
        r.x = x;
        r.d = d;
        r.v = eval_derivative(x, d);
        pending_values.push_back(r);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid = 1'b0;
        while (pending_values.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(4 * idx);
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_DEGREE)
        begin
            degree_shadow = data[DEG_W-1:0];
        end
        else
        begin
            coef_shadow[idx - REG_COEF0] = data[COEF_W-1:0];
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // write the degree and every coefficient; junk fills the unused upper data bits
    task automatic load_poly(int deg, logic signed [COEF_W-1:0] c [MAX_DEG+1], bit junk);
        logic [DATA_W-1:0] hi;
        hi = junk ? DATA_W'($urandom) : '0;
        write_reg(REG_DEGREE, {hi[DATA_W-1:DEG_W], DEG_W'(deg)});
        for (int k = 0; k <= MAX_DEG; k++)
        begin
            hi = junk ? DATA_W'($urandom) : {DATA_W{c[k][COEF_W-1]}};
            write_reg(REG_COEF0 + IDX_W'(k), {hi[DATA_W-1:COEF_W], c[k]});
        end
    endtask

    function automatic logic signed [POINT_W-1:0] pick_point();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sd0;
            3: return POINT_W'($urandom_range(0, 6)) - 16'sd3;
            default: return POINT_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return COEF_W'($urandom_range(0, 8)) - 16'sd4;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic logic [ORDER_W-1:0] pick_order();
        int top;
        top = (int'(degree_shadow) > MAX_DEG) ? MAX_DEG : int'(degree_shadow);
        if ($urandom_range(0, 7) == 0)
        begin
            return ORDER_W'($urandom_range(0, 15));
        end
        return ORDER_W'($urandom_range(0, top + 1));
    endfunction

    // after reset the polynomial is zero everywhere
    task automatic check_reset_state();
        send_point(16'sh7fff, 4'd0);
        send_point(16'sh8000, 4'd15);
        wait_drained();
    endtask

    task automatic check_corner_cases();
        logic signed [COEF_W-1:0] c [MAX_DEG+1];
        // full degree, all coefficients at the top: overflow on large points
        foreach (c[k]) c[k] = 16'sh7fff;
        load_poly(MAX_DEG, c, 1'b0);
        send_point(16'sh7fff, 4'd0);
        send_point(16'sh8000, 4'd0);
        send_point(16'sh8000, 4'd6);
        send_point(16'sh7fff, 4'd1);
        send_point(16'sd0, 4'd3);
        send_point(-16'sd1, 4'd5);
        wait_drained();
        // degree register above the supported degree saturates
        foreach (c[k]) c[k] = 16'sh8000;
        load_poly(7, c, 1'b0);
        send_point(16'sh8000, 4'd0);
        send_point(16'sh7fff, 4'd6);
        send_point(16'sd1, 4'd7);
        send_point(16'sh8000, 4'd15);
        send_point(16'sh7fff, 4'd2);
        wait_drained();
        // constant polynomial: any derivative is zero
        foreach (c[k]) c[k] = 16'sd0;
        c[0] = 16'sd12345;
        c[3] = -16'sd77;
        load_poly(0, c, 1'b1);
        send_point(16'sd5, 4'd0);
        send_point(16'sd5, 4'd1);
        send_point(16'sh8000, 4'd0);
        wait_drained();
    endtask

    task automatic check_random_polys();
        logic signed [COEF_W-1:0] c [MAX_DEG+1];
        int n;
        for (int phase = 0; phase < 14; phase++)
        begin
            idle_on = (phase % 4 != 3);
            foreach (c[k]) c[k] = pick_coef();
            load_poly($urandom_range(0, 7), c, phase[0]);
            n = $urandom_range(80, 120);
            for (int i = 0; i < n; i++)
            begin
                // hold off new points until the pipeline empties
                if (phase == 5 && i == n / 2)
                begin
                    wait_drained();
                end
                send_point(pick_point(), pick_order());
            end
            wait_drained();
        end
    endtask

    // final stretch at full rate on both sides
    task automatic check_full_rate();
        logic signed [COEF_W-1:0] c [MAX_DEG+1];
        idle_on = 1'b0;
        foreach (c[k]) c[k] = pick_coef();
        load_poly(MAX_DEG, c, 1'b0);
        for (int i = 0; i < 150; i++)
        begin
            send_point(pick_point(), pick_order());
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        item_valid  = 1'b0;
        point       = '0;
        deriv_order = '0;
        idle_on     = 1'b1;
        degree_shadow = '0;
        foreach (coef_shadow[k]) coef_shadow[k] = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        check_reset_state();
        check_corner_cases();
        check_random_polys();
        check_full_rate();

        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
